FILE: hw/rtl/etc_pkg.sv
package etc_pkg;

    localparam logic [2:0] CAT_LIT  = 3'd0;
    localparam logic [2:0] CAT_VAR  = 3'd1;
    localparam logic [2:0] CAT_UN   = 3'd2;
    localparam logic [2:0] CAT_BIN  = 3'd3;
    localparam logic [2:0] CAT_LB   = 3'd4;
    localparam logic [2:0] CAT_RB   = 3'd5;
    localparam logic [2:0] CAT_NONE = 3'd7;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    localparam logic [2:0] PREC_NONE = 3'd0;
    localparam logic [2:0] PREC_ADD  = 3'd1;
    localparam logic [2:0] PREC_MUL  = 3'd2;
    localparam logic [2:0] PREC_POW  = 3'd3;
    localparam logic [2:0] PREC_UN   = 3'd4;
    localparam logic [2:0] PREC_RB   = 3'd5;

    localparam logic [7:0] MAX_DEPTH = 8'd255;
    localparam logic [3:0] MAX_FRAC  = 4'd9;
    localparam int         DATA_W    = 56;

    typedef enum logic [3:0] {
        CL_OTHER = 4'd0,
        CL_DIGIT = 4'd1,
        CL_DOT   = 4'd2,
        CL_SPACE = 4'd3,
        CL_LB    = 4'd4,
        CL_RB    = 4'd5,
        CL_PLUS  = 4'd6,
        CL_MINUS = 4'd7,
        CL_STAR  = 4'd8,
        CL_SLASH = 4'd9,
        CL_CARET = 4'd10,
        CL_X     = 4'd11
    } cls_t;

    typedef struct packed {
        logic [7:0] code;
        cls_t       cls;
        logic       last;
    } qent_t;

    typedef struct packed {
        logic        is_verdict;
        logic [2:0]  category;
        logic [2:0]  op_code;
        logic [2:0]  precedence;
        logic [31:0] mantissa;
        logic [3:0]  frac_digits;
        logic        negative;
        logic        is_pi;
        logic        valid_res;
        logic        has_variable;
    } res_t;

    function automatic cls_t char_class(input logic [7:0] c);
        cls_t r;
        r = CL_OTHER;
        if (c >= 8'h30 && c <= 8'h39) r = CL_DIGIT;
        else if (c == 8'h2e) r = CL_DOT;
        else if (c == 8'h20) r = CL_SPACE;
        else if (c == 8'h28) r = CL_LB;
        else if (c == 8'h29) r = CL_RB;
        else if (c == 8'h2b) r = CL_PLUS;
        else if (c == 8'h2d) r = CL_MINUS;
        else if (c == 8'h2a) r = CL_STAR;
        else if (c == 8'h2f) r = CL_SLASH;
        else if (c == 8'h5e) r = CL_CARET;
        else if (c == 8'h78) r = CL_X;
        return r;
    endfunction

    function automatic logic no_star(input cls_t c);
        return c == CL_DIGIT || c == CL_DOT || c == CL_RB || c == CL_MINUS ||
               c == CL_PLUS || c == CL_STAR || c == CL_SLASH || c == CL_CARET;
    endfunction

endpackage

FILE: hw/rtl/etc_front.sv
module etc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,  // char_code
    input  logic              s_axis_tlast,
    output logic              q_valid,
    output etc_pkg::qent_t    q_data,
    input  logic              q_pop
);

    etc_pkg::qent_t ent_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           push;

    assign s_axis_tready = cnt_reg != 2'd2;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = cnt_reg != 2'd0;
    assign q_data        = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg].code <= s_axis_tdata;
            ent_reg[wr_ptr_reg].cls  <= etc_pkg::char_class(s_axis_tdata);
            ent_reg[wr_ptr_reg].last <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop && q_valid)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
        end
    end

endmodule

FILE: hw/rtl/etc_back.sv
module etc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  etc_pkg::qent_t               q_data,
    output logic                         q_pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [etc_pkg::DATA_W-1:0]   m_axis_tdata,
    output logic                         m_axis_tuser,
    output logic                         m_axis_tlast
);

    typedef enum logic [3:0] {
        PH_MAIN    = 4'b0001,
        PH_NUMSTAR = 4'b0010,
        PH_SW      = 4'b0100,
        PH_SECOND  = 4'b1000
    } ph_t;

    logic [7:0]      win_code_reg [4];
    etc_pkg::cls_t   win_cls_reg  [4];
    logic [2:0]      fill_reg;
    logic            drain_reg;
    ph_t             ph_reg;
    logic [2:0]      prev_reg;
    logic [7:0]      depth_reg;
    logic [31:0]     num_val_reg;
    logic [3:0]      num_frac_reg;
    logic            act_reg, pt_reg, stop_reg, neg_reg;
    logic            err_reg, var_reg;
    logic            held_v_reg, held_fin_reg;
    etc_pkg::res_t   held_reg;
    logic            out_v_reg, out_last_reg;
    etc_pkg::res_t   out_reg;

    logic [7:0]      win_code_next [4];
    etc_pkg::cls_t   win_cls_next  [4];
    logic [2:0]      fill_next;
    logic            drain_next;
    ph_t             ph_next;
    logic [2:0]      prev_next;
    logic [7:0]      depth_next;
    logic [31:0]     num_val_next;
    logic [3:0]      num_frac_next;
    logic            act_next, pt_next, stop_next, neg_next;
    logic            err_next, var_next;

    logic            gen, end_step, cons, do_sw, do_num, clr_all;
    logic [2:0]      cons_k;
    etc_pkg::res_t   tok;
    logic            active, fin_mode, eng_ok, out_free, push, load;
    logic [2:0]      fill_after;
    logic [7:0]      c0, c1, c2, c3;
    etc_pkg::cls_t   cc, nc;
    logic            n_ok;
    logic [7:0]      fmatch;
    logic [35:0]     prod;
    logic            p_operand;

    assign c0 = win_code_reg[0];
    assign c1 = win_code_reg[1];
    assign c2 = win_code_reg[2];
    assign c3 = win_code_reg[3];
    assign cc = win_cls_reg[0];
    assign nc = win_cls_reg[1];
    assign n_ok = fill_reg >= 3'd2;

    assign fmatch[0] = fill_reg >= 3'd3 && c0 == "c" && c1 == "o" && c2 == "s";
    assign fmatch[1] = fill_reg >= 3'd3 && c0 == "s" && c1 == "i" && c2 == "n";
    assign fmatch[2] = fill_reg >= 3'd3 && c0 == "t" && c1 == "a" && c2 == "n";
    assign fmatch[3] = fill_reg >= 3'd3 && c0 == "l" && c1 == "o" && c2 == "g";
    assign fmatch[4] = fill_reg == 3'd4 && c0 == "s" && c1 == "q" && c2 == "r" && c3 == "t";
    assign fmatch[5] = fill_reg == 3'd4 && c0 == "a" && c1 == "c" && c2 == "o" && c3 == "s";
    assign fmatch[6] = fill_reg == 3'd4 && c0 == "a" && c1 == "s" && c2 == "i" && c3 == "n";
    assign fmatch[7] = fill_reg == 3'd4 && c0 == "a" && c1 == "t" && c2 == "a" && c3 == "n";

    assign active   = ph_reg != PH_MAIN || fill_reg == 3'd4 || (drain_reg && fill_reg != 3'd0);
    assign fin_mode = ph_reg == PH_MAIN && drain_reg && fill_reg == 3'd0;
    assign out_free = !out_v_reg || m_axis_tready;
    assign eng_ok   = !(held_v_reg && (gen || end_step)) || out_free;
    assign push     = held_v_reg && (held_fin_reg || gen || end_step) && out_free;
    assign p_operand = prev_reg == etc_pkg::CAT_LIT || prev_reg == etc_pkg::CAT_VAR ||
                       prev_reg == etc_pkg::CAT_RB;

    always_comb
    begin
        gen = 1'b0;
        end_step = 1'b0;
        cons = 1'b0;
        cons_k = 3'd1;
        do_sw = 1'b0;
        do_num = 1'b0;
        clr_all = 1'b0;
        tok = '0;
        ph_next = ph_reg;
        prev_next = prev_reg;
        depth_next = depth_reg;
        num_val_next = num_val_reg;
        num_frac_next = num_frac_reg;
        act_next = act_reg;
        pt_next = pt_reg;
        stop_next = stop_reg;
        neg_next = neg_reg;
        err_next = err_reg;
        var_next = var_reg;
        drain_next = drain_reg;
        prod = '0;

        if (fin_mode)
        begin
            gen = 1'b1;
            if (act_reg)
            begin
                tok.category = etc_pkg::CAT_LIT;
                tok.mantissa = num_val_reg;
                tok.frac_digits = num_frac_reg;
                tok.negative = neg_reg;
                {num_val_next, num_frac_next} = '0;
                {act_next, pt_next, stop_next, neg_next} = '0;
            end
            else
            begin
                tok.is_verdict = 1'b1;
                tok.valid_res = !err_reg && prev_reg != etc_pkg::CAT_NONE &&
                                prev_reg != etc_pkg::CAT_BIN &&
                                prev_reg != etc_pkg::CAT_UN && depth_reg == 8'd0;
                tok.has_variable = var_reg;
                end_step = 1'b1;
                clr_all = 1'b1;
            end
        end
        else if (active)
        begin
            unique case (ph_reg)
                PH_MAIN:
                begin
                    if (act_reg && (cc == etc_pkg::CL_DIGIT || cc == etc_pkg::CL_DOT))
                    begin
                        do_num = 1'b1;
                        cons = 1'b1;
                        end_step = !drain_reg;
                    end
                    else if (act_reg)
                    begin
                        gen = 1'b1;
                        tok.category = etc_pkg::CAT_LIT;
                        tok.mantissa = num_val_reg;
                        tok.frac_digits = num_frac_reg;
                        tok.negative = neg_reg;
                        {num_val_next, num_frac_next} = '0;
                        {act_next, pt_next, stop_next, neg_next} = '0;
                        ph_next = PH_NUMSTAR;
                    end
                    else
                        do_sw = 1'b1;
                end
                PH_NUMSTAR:
                begin
                    if (!etc_pkg::no_star(cc))
                    begin
                        gen = 1'b1;
                        tok.category = etc_pkg::CAT_BIN;
                        tok.op_code = etc_pkg::OP_MUL;
                        tok.precedence = etc_pkg::PREC_MUL;
                        ph_next = PH_SW;
                    end
                    else
                        do_sw = 1'b1;
                end
                PH_SW:
                    do_sw = 1'b1;
                PH_SECOND:
                begin
                    gen = 1'b1;
                    tok.category = etc_pkg::CAT_BIN;
                    tok.op_code = etc_pkg::OP_MUL;
                    tok.precedence = etc_pkg::PREC_MUL;
                    ph_next = PH_MAIN;
                    cons = 1'b1;
                    end_step = !drain_reg;
                end
                default: ph_next = PH_MAIN;
            endcase
        end

        if (do_sw)
        begin
            ph_next = PH_MAIN;
            cons = 1'b1;
            end_step = !drain_reg;
            unique case (cc)
                etc_pkg::CL_SPACE: ;
                etc_pkg::CL_LB:
                begin
                    gen = 1'b1;
                    tok.category = etc_pkg::CAT_LB;
                end
                etc_pkg::CL_PLUS:
                begin
                    gen = 1'b1;
                    tok.category = etc_pkg::CAT_BIN;
                    tok.op_code = etc_pkg::OP_ADD;
                    tok.precedence = etc_pkg::PREC_ADD;
                end
                etc_pkg::CL_STAR:
                begin
                    gen = 1'b1;
                    tok.category = etc_pkg::CAT_BIN;
                    tok.op_code = etc_pkg::OP_MUL;
                    tok.precedence = etc_pkg::PREC_MUL;
                end
                etc_pkg::CL_SLASH:
                begin
                    gen = 1'b1;
                    tok.category = etc_pkg::CAT_BIN;
                    tok.op_code = etc_pkg::OP_DIV;
                    tok.precedence = etc_pkg::PREC_MUL;
                end
                etc_pkg::CL_CARET:
                begin
                    gen = 1'b1;
                    tok.category = etc_pkg::CAT_BIN;
                    tok.op_code = etc_pkg::OP_POW;
                    tok.precedence = etc_pkg::PREC_POW;
                end
                etc_pkg::CL_RB, etc_pkg::CL_X:
                begin
                    gen = 1'b1;
                    if (cc == etc_pkg::CL_RB)
                    begin
                        tok.category = etc_pkg::CAT_RB;
                        tok.precedence = etc_pkg::PREC_RB;
                    end
                    else
                    begin
                        tok.category = etc_pkg::CAT_VAR;
                        var_next = 1'b1;
                    end
                    if (n_ok && !etc_pkg::no_star(nc))
                    begin
                        ph_next = PH_SECOND;
                        cons = 1'b0;
                        end_step = 1'b0;
                    end
                end
                etc_pkg::CL_MINUS:
                begin
                    if (p_operand)
                    begin
                        gen = 1'b1;
                        tok.category = etc_pkg::CAT_BIN;
                        tok.op_code = etc_pkg::OP_SUB;
                        tok.precedence = etc_pkg::PREC_ADD;
                    end
                    else if (prev_reg == etc_pkg::CAT_LB || ((prev_reg == etc_pkg::CAT_BIN ||
                             prev_reg == etc_pkg::CAT_NONE) && n_ok))
                    begin
                        if (prev_reg != etc_pkg::CAT_LB &&
                            (nc == etc_pkg::CL_DIGIT || nc == etc_pkg::CL_DOT))
                        begin
                            act_next = 1'b1;
                            neg_next = 1'b1;
                        end
                        else
                        begin
                            gen = 1'b1;
                            tok.category = etc_pkg::CAT_LIT;
                            tok.mantissa = 32'd1;
                            tok.negative = 1'b1;
                            ph_next = PH_SECOND;
                            cons = 1'b0;
                            end_step = 1'b0;
                        end
                    end
                end
                default:
                begin
                    if (fmatch != 8'd0)
                    begin
                        gen = 1'b1;
                        tok.category = etc_pkg::CAT_UN;
                        tok.precedence = etc_pkg::PREC_UN;
                        for (int i = 7; i >= 0; i--)
                        begin
                            if (fmatch[i])
                                tok.op_code = 3'(i);
                        end
                        cons_k = (fmatch[3:0] != 4'd0) ? 3'd3 : 3'd4;
                    end
                    else if (n_ok && ((c0 == "p" && c1 == "i") ||
                             (c0 == "P" && (c1 == "I" || c1 == "i"))))
                    begin
                        gen = 1'b1;
                        tok.category = etc_pkg::CAT_LIT;
                        tok.is_pi = 1'b1;
                        cons_k = 3'd2;
                    end
                    else if (cc == etc_pkg::CL_DIGIT || cc == etc_pkg::CL_DOT)
                    begin
                        act_next = 1'b1;
                        do_num = 1'b1;
                    end
                    else
                        err_next = 1'b1;
                end
            endcase
        end

        if (do_num)
        begin
            if (cc == etc_pkg::CL_DOT)
            begin
                if (pt_reg)
                    stop_next = 1'b1;
                else
                    pt_next = 1'b1;
            end
            else if (!stop_reg && !(pt_reg && num_frac_reg >= etc_pkg::MAX_FRAC))
            begin
                if (pt_reg)
                    num_frac_next = num_frac_reg + 4'd1;
                prod = ({4'd0, num_val_reg} << 3) + ({4'd0, num_val_reg} << 1) +
                       {32'd0, c0[3:0]};
                num_val_next = (prod[35:32] != 4'd0) ? '1 : prod[31:0];
            end
        end

        if (gen && !tok.is_verdict)
        begin
            if ((prev_reg == etc_pkg::CAT_UN && tok.category != etc_pkg::CAT_LB) ||
                (tok.category == etc_pkg::CAT_BIN && (prev_reg == etc_pkg::CAT_NONE ||
                 prev_reg == etc_pkg::CAT_BIN || prev_reg == etc_pkg::CAT_LB)) ||
                (prev_reg == etc_pkg::CAT_BIN && tok.category == etc_pkg::CAT_RB) ||
                (p_operand && (tok.category == etc_pkg::CAT_LIT ||
                 tok.category == etc_pkg::CAT_VAR)) ||
                (prev_reg == etc_pkg::CAT_LB && tok.category == etc_pkg::CAT_RB))
                err_next = 1'b1;
            if (tok.category == etc_pkg::CAT_LB)
            begin
                if (depth_reg >= etc_pkg::MAX_DEPTH)
                    err_next = 1'b1;
                else
                    depth_next = depth_reg + 8'd1;
            end
            if (tok.category == etc_pkg::CAT_RB)
            begin
                if (depth_reg != 8'd0)
                    depth_next = depth_reg - 8'd1;
                else
                    err_next = 1'b1;
            end
            prev_next = tok.category;
        end

        for (int i = 0; i < 4; i++)
        begin
            win_code_next[i] = win_code_reg[i];
            win_cls_next[i] = win_cls_reg[i];
        end
        fill_after = fill_reg;
        if (cons)
        begin
            fill_after = fill_reg - ((cons_k > fill_reg) ? fill_reg : cons_k);
            for (int i = 0; i < 4; i++)
            begin
                if (i + int'(cons_k) < 4)
                begin
                    win_code_next[i] = win_code_reg[2'(i + int'(cons_k))];
                    win_cls_next[i] = win_cls_reg[2'(i + int'(cons_k))];
                end
                else
                begin
                    win_code_next[i] = 8'd0;
                    win_cls_next[i] = etc_pkg::CL_OTHER;
                end
            end
        end

        load = !drain_reg && q_valid && eng_ok && (!active || cons) && fill_after <= 3'd3;
        fill_next = fill_after;
        if (load)
        begin
            win_code_next[fill_after[1:0]] = q_data.code;
            win_cls_next[fill_after[1:0]] = q_data.cls;
            fill_next = fill_after + 3'd1;
            drain_next = q_data.last;
        end

        if (clr_all)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_code_next[i] = 8'd0;
                win_cls_next[i] = etc_pkg::CL_OTHER;
            end
            fill_next = 3'd0;
            drain_next = 1'b0;
            prev_next = etc_pkg::CAT_NONE;
            depth_next = 8'd0;
            {num_val_next, num_frac_next} = '0;
            {act_next, pt_next, stop_next, neg_next} = '0;
            err_next = 1'b0;
            var_next = 1'b0;
        end
    end

    assign q_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_code_reg[i] <= 8'd0;
                win_cls_reg[i] <= etc_pkg::CL_OTHER;
            end
            fill_reg <= 3'd0;
            drain_reg <= 1'b0;
            ph_reg <= PH_MAIN;
            prev_reg <= etc_pkg::CAT_NONE;
            depth_reg <= 8'd0;
            num_val_reg <= 32'd0;
            num_frac_reg <= 4'd0;
            {act_reg, pt_reg, stop_reg, neg_reg} <= 4'd0;
            err_reg <= 1'b0;
            var_reg <= 1'b0;
            held_v_reg <= 1'b0;
            held_fin_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (eng_ok)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    win_code_reg[i] <= win_code_next[i];
                    win_cls_reg[i] <= win_cls_next[i];
                end
                fill_reg <= fill_next;
                drain_reg <= drain_next;
                ph_reg <= ph_next;
                prev_reg <= prev_next;
                depth_reg <= depth_next;
                num_val_reg <= num_val_next;
                num_frac_reg <= num_frac_next;
                {act_reg, pt_reg, stop_reg, neg_reg} <=
                    {act_next, pt_next, stop_next, neg_next};
                err_reg <= err_next;
                var_reg <= var_next;
            end
            if (eng_ok && gen)
            begin
                held_v_reg <= 1'b1;
                held_fin_reg <= end_step;
            end
            else if (push)
                held_v_reg <= 1'b0;
            if (push)
                out_v_reg <= 1'b1;
            else if (m_axis_tready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_ok && gen)
            held_reg <= tok;
        if (push)
        begin
            out_reg <= held_reg;
            out_last_reg <= held_fin_reg || (end_step && !gen);
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = out_reg.is_verdict;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_reg.has_variable, out_reg.valid_res, out_reg.is_pi,
                            out_reg.negative, out_reg.frac_digits, out_reg.mantissa,
                            out_reg.precedence, out_reg.op_code, out_reg.category};

endmodule

FILE: hw/rtl/expression_tokenizer_checker.sv
// expression tokenizer and syntax checker
// s_axis carries one ascii character per item in tdata, tlast on the final
// character of an expression. m_axis carries result items: tuser 0 for a
// token, 1 for the end-of-expression verdict; tlast marks the last result
// caused by one input character.
// a 2-entry queue parts the character front from the token engine, so the
// input keeps flowing while results wait. the engine decides the head of a
// 4-character window and produces one token per cycle while the output is
// not stalled; a character that causes several tokens produces them one after
// another. a character is decided only once three more stand behind it or the
// expression ends. at the end the window drains one token per cycle, then
// the verdict follows and all expression state clears.
// reset empties queue, window and output and starts a fresh expression.
// when the receiver stalls the output and hold registers fill, then the
// engine and queue stop and s_axis_tready drops.
module expression_tokenizer_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // char_code
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // category, op_code, precedence, literal_mantissa, literal_frac_digits,
    // literal_negative, literal_is_pi, valid_res, has_variable, zero pad
    output logic [etc_pkg::DATA_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tuser,  // is_verdict
    output logic                        m_axis_tlast
);

    logic           q_valid;
    logic           q_pop;
    etc_pkg::qent_t q_data;

    etc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop)
    );

    etc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: tb/sv/expression_tokenizer_checker_chk.sv
module expression_tokenizer_checker_chk
    import etc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                s_axis_tlast,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [DATA_W-1:0]   m_axis_tdata,
    input  logic                m_axis_tuser,
    input  logic                m_axis_tlast,
    output int                  mismatches,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        res_t r;
        logic l;
    } token_exp_t;

    token_exp_t token_q[$];
    res_t       step_q[$];

    logic [7:0]  win [4];
    int          win_fill;
    logic [2:0]  prev_cat;
    int          depth;
    logic [63:0] num_val;
    int          num_frac;
    logic        num_act, num_pt, num_stop, num_neg;
    logic        err_seen, var_seen;

    string fn_names [8] = '{"cos", "sin", "tan", "log", "sqrt", "acos", "asin", "atan"};

    task automatic clear_expr();
        for (int i = 0; i < 4; i++)
            win[i] = 8'd0;
        win_fill = 0;
        prev_cat = CAT_NONE;
        depth = 0;
        num_val = 0;
        num_frac = 0;
        {num_act, num_pt, num_stop, num_neg} = 4'b0;
        err_seen = 1'b0;
        var_seen = 1'b0;
    endtask

    function automatic int peek(int i);
        return (i < win_fill) ? int'(win[i]) : -1;
    endfunction

    function automatic bit is_dig(int c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit skips_star(int c);
        return is_dig(c) || c == "." || c == ")" || c == "-" || c == "+" ||
               c == "*" || c == "/" || c == "^";
    endfunction

    task automatic put(res_t r);
        if (step_q.size() < 10)
            step_q.push_back(r);
    endtask

    task automatic emit_token(logic [2:0] cat, logic [2:0] op, logic [2:0] prec,
                              logic [31:0] mant, logic [3:0] frac, logic neg, logic pi);
        res_t r;
        bit   p_operand;
        p_operand = prev_cat == CAT_LIT || prev_cat == CAT_VAR || prev_cat == CAT_RB;
        if (prev_cat == CAT_UN && cat != CAT_LB) err_seen = 1'b1;
        if (cat == CAT_BIN && (prev_cat == CAT_NONE || prev_cat == CAT_BIN ||
                               prev_cat == CAT_LB)) err_seen = 1'b1;
        if (prev_cat == CAT_BIN && cat == CAT_RB) err_seen = 1'b1;
        if (p_operand && (cat == CAT_LIT || cat == CAT_VAR)) err_seen = 1'b1;
        if (prev_cat == CAT_LB && cat == CAT_RB) err_seen = 1'b1;
        if (cat == CAT_LB) begin
            if (depth >= int'(MAX_DEPTH))
                err_seen = 1'b1;
            else
                depth++;
        end
        if (cat == CAT_RB) begin
            if (depth > 0)
                depth--;
            else
                err_seen = 1'b1;
        end
        prev_cat = cat;
        r = '0;
        r.category = cat;
        r.op_code = op;
        r.precedence = prec;
        r.mantissa = mant;
        r.frac_digits = frac;
        r.negative = neg;
        r.is_pi = pi;
        put(r);
    endtask

    task automatic implied_mul(int nxt);
        if (nxt >= 0 && !skips_star(nxt))
            emit_token(CAT_BIN, OP_MUL, PREC_MUL, 0, 0, 0, 0);
    endtask

    task automatic minus_one_mul();
        emit_token(CAT_LIT, OP_ADD, PREC_NONE, 1, 0, 1, 0);
        emit_token(CAT_BIN, OP_MUL, PREC_MUL, 0, 0, 0, 0);
    endtask

    task automatic add_digit(int c);
        if (c == ".") begin
            if (num_pt)
                num_stop = 1'b1;
            else
                num_pt = 1'b1;
            return;
        end
        if (num_stop)
            return;
        if (num_pt) begin
            if (num_frac >= int'(MAX_FRAC))
                return;
            num_frac++;
        end
        num_val = num_val * 10 + (c - "0");
        if (num_val > 64'hFFFF_FFFF)
            num_val = 64'hFFFF_FFFF;
    endtask

    task automatic close_number(int nxt);
        emit_token(CAT_LIT, OP_ADD, PREC_NONE, num_val[31:0], num_frac[3:0], num_neg, 0);
        num_val = 0;
        num_frac = 0;
        {num_act, num_pt, num_stop, num_neg} = 4'b0;
        implied_mul(nxt);
    endtask

    function automatic bit word_here(string w);
        for (int i = 0; i < w.len(); i++)
            if (peek(i) != int'(w[i]))
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic decide_head(output int used);
        int c, n;
        c = peek(0);
        n = peek(1);
        used = 1;
        if (num_act) begin
            if (is_dig(c) || c == ".") begin
                add_digit(c);
                return;
            end
            close_number(c);
        end
        case (c)
            " ": return;
            "(": begin emit_token(CAT_LB, 0, PREC_NONE, 0, 0, 0, 0); return; end
            "+": begin emit_token(CAT_BIN, OP_ADD, PREC_ADD, 0, 0, 0, 0); return; end
            "*": begin emit_token(CAT_BIN, OP_MUL, PREC_MUL, 0, 0, 0, 0); return; end
            "/": begin emit_token(CAT_BIN, OP_DIV, PREC_MUL, 0, 0, 0, 0); return; end
            "^": begin emit_token(CAT_BIN, OP_POW, PREC_POW, 0, 0, 0, 0); return; end
            ")": begin
                emit_token(CAT_RB, 0, PREC_RB, 0, 0, 0, 0);
                implied_mul(n);
                return;
            end
            "x": begin
                emit_token(CAT_VAR, 0, PREC_NONE, 0, 0, 0, 0);
                var_seen = 1'b1;
                implied_mul(n);
                return;
            end
            "-": begin
                if (prev_cat == CAT_LIT || prev_cat == CAT_VAR || prev_cat == CAT_RB)
                    emit_token(CAT_BIN, OP_SUB, PREC_ADD, 0, 0, 0, 0);
                else if (prev_cat == CAT_LB)
                    minus_one_mul();
                else if (prev_cat == CAT_BIN || prev_cat == CAT_NONE) begin
                    if (n >= 0) begin
                        if (is_dig(n) || n == ".") begin
                            num_act = 1'b1;
                            num_neg = 1'b1;
                        end
                        else
                            minus_one_mul();
                    end
                end
                return;
            end
            default: ;
        endcase
        for (int k = 0; k < 8; k++)
            if (word_here(fn_names[k])) begin
                emit_token(CAT_UN, 3'(k), PREC_UN, 0, 0, 0, 0);
                used = (k < 4) ? 3 : 4;
                return;
            end
        if ((c == "p" && n == "i") || (c == "P" && (n == "I" || n == "i"))) begin
            emit_token(CAT_LIT, 0, PREC_NONE, 0, 0, 0, 1);
            used = 2;
            return;
        end
        if (is_dig(c) || c == ".") begin
            num_act = 1'b1;
            add_digit(c);
            return;
        end
        err_seen = 1'b1;
    endtask

    task automatic shift_out(int k);
        if (k > win_fill)
            k = win_fill;
        for (int i = 0; i < 4; i++)
            win[i] = (i + k < 4) ? win[i + k] : 8'd0;
        win_fill -= k;
    endtask

    task automatic tokenize_char(logic [7:0] code, logic fin);
        int   used;
        res_t v;
        step_q.delete();
        if (win_fill > 3)
            win_fill = 3;
        win[win_fill] = code;
        win_fill++;
        if (!fin) begin
            if (win_fill == 4) begin
                decide_head(used);
                shift_out(used);
            end
        end
        else begin
            while (win_fill > 0) begin
                decide_head(used);
                shift_out(used);
            end
            if (num_act)
                close_number(-1);
            v = '0;
            v.is_verdict = 1'b1;
            v.valid_res = !err_seen && prev_cat != CAT_NONE && prev_cat != CAT_BIN &&
                          prev_cat != CAT_UN && depth == 0;
            v.has_variable = var_seen;
            put(v);
            clear_expr();
        end
        foreach (step_q[i])
            token_q.push_back('{r: step_q[i], l: (i == step_q.size() - 1)});
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
        pending = 0;
        clear_expr();
    end

    always @(posedge clk) begin
        token_exp_t e;
        res_t       g;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                tokenize_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (token_q.size() == 0)
                    report("unexpected item", m_axis_tdata, 0);
                else begin
                    e = token_q.pop_front();
                    g = '0;
                    g.is_verdict = m_axis_tuser;
                    {g.has_variable, g.valid_res, g.is_pi, g.negative, g.frac_digits,
                     g.mantissa, g.precedence, g.op_code, g.category} = m_axis_tdata[48:0];
                    if (g.is_verdict != e.r.is_verdict)
                        report("is_verdict", g.is_verdict, e.r.is_verdict);
                    if (g.category != e.r.category)
                        report("category", g.category, e.r.category);
                    if (g.op_code != e.r.op_code)
                        report("op_code", g.op_code, e.r.op_code);
                    if (g.precedence != e.r.precedence)
                        report("precedence", g.precedence, e.r.precedence);
                    if (g.mantissa != e.r.mantissa)
                        report("literal_mantissa", g.mantissa, e.r.mantissa);
                    if (g.frac_digits != e.r.frac_digits)
                        report("literal_frac_digits", g.frac_digits, e.r.frac_digits);
                    if (g.negative != e.r.negative)
                        report("literal_negative", g.negative, e.r.negative);
                    if (g.is_pi != e.r.is_pi)
                        report("literal_is_pi", g.is_pi, e.r.is_pi);
                    if (g.valid_res != e.r.valid_res)
                        report("valid_res", g.valid_res, e.r.valid_res);
                    if (g.has_variable != e.r.has_variable)
                        report("has_variable", g.has_variable, e.r.has_variable);
                    if (m_axis_tdata[DATA_W-1:49] != '0)
                        report("pad", m_axis_tdata[DATA_W-1:49], 0);
                    if (m_axis_tlast != e.l)
                        report("tlast", m_axis_tlast, e.l);
                end
            end
            pending = token_q.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
module tb;
    import etc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [DATA_W-1:0]  m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;

    int mismatches;
    int pending;
    int send_idle;
    int recv_idle;
    bit hold_req;
    int cycles;

    string fn_names [8] = '{"cos", "sin", "tan", "log", "sqrt", "acos", "asin", "atan"};
    string pi_names [3] = '{"pi", "PI", "Pi"};

    expression_tokenizer_checker dut (.*);

    expression_tokenizer_checker_chk chk (.*);

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver side, with a long hold-off on request
    initial begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && hold == 0) begin
                hold = 300;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_char(logic [7:0] c, logic fin);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_expr(string s, output int n);
        n = s.len();
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic string gen_number();
        string s;
        int nd;
        s = "";
        nd = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
        for (int i = 0; i < nd; i++)
            s = {s, $sformatf("%0d", $urandom_range(9))};
        if ($urandom_range(3) == 0)
            s = {s, ".", $sformatf("%0d", $urandom_range(999))};
        return s;
    endfunction

    function automatic string gen_term(int d);
        case ($urandom_range(d > 0 ? 7 : 3))
            0: return gen_number();
            1: return "x";
            2: return pi_names[$urandom_range(2)];
            3: return $urandom_range(1) ? {"-", gen_number()} : "-x";
            4: return {"(", gen_expr(d - 1), ")"};
            5: return {fn_names[$urandom_range(7)], "(", gen_expr(d - 1), ")"};
            6: return {gen_number(), $urandom_range(1) ? "x" : "(x)"};
            default: return {"x ", gen_term(d - 1)};
        endcase
    endfunction

    function automatic string gen_expr(int d);
        string s;
        string ops;
        ops = "+-*/^";
        s = gen_term(d);
        repeat ($urandom_range(2)) begin
            s = {s, ops.substr($urandom_range(4), 0)};
            s = {s, gen_term(d)};
        end
        return s;
    endfunction

    function automatic string gen_noise();
        string s;
        int n;
        if ($urandom_range(1)) begin
            s = "";
            repeat ($urandom_range(1, 5))
                s = {s, $sformatf("%c", 8'($urandom_range(1, 255)))};
            return s;
        end
        s = gen_expr(2);
        n = $urandom_range(1, s.len());
        return s.substr(0, n - 1);
    endfunction

    task automatic settle();
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    initial begin
        string directed [$];
        string s;
        string deep;
        int n;
        int sent;
        send_idle = 0;
        recv_idle = 0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tlast = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed = '{"1+2", "-3.25*x", "sin(x)+cos(x)^2", "acos(x)/atan(x)",
                     "asin(-x)", "tan(x)-log(2)", "sqrt(x)", "2x", "x (x)", "(-x)",
                     "Pi*PI+pi", "99999999999", ".1234567891234", "1.2.3x", "-",
                     "5-", "sin-x", "((", ")", "x$", "()", "x+*2", "-(x)"};
        directed.push_back($sformatf("%c", 8'hff));
        directed.push_back($sformatf("%c", 8'h80));
        foreach (directed[i])
            send_expr(directed[i], n);
        deep = "";
        repeat (256) deep = {deep, "("};
        deep = {deep, "x"};
        repeat (255) deep = {deep, ")"};
        send_expr(deep, n);
        s_axis_tvalid <= 1'b0;
        settle();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 24 : (ph == 1) ? 59 : 0;
            recv_idle = (ph == 0) ? 59 : (ph == 1) ? 24 : 0;
            sent = 0;
            if (ph == 2)
                hold_req = 1'b1;
            while (sent < 85) begin
                s = ($urandom_range(99) < 20) ? gen_noise() : gen_expr(2);
                send_expr(s, n);
                sent += n;
                if ($urandom_range(9) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(negedge clk);
                end
            end
            s_axis_tvalid <= 1'b0;
            settle();
        end

        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
